FILE: hdl/lqfl_pkg.sv
// ----------------------------------------------------------------------------
// Linked queue package
// Shared widths, pointer encoding, operation and status codes.
// ----------------------------------------------------------------------------
package lqfl_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int PTR_W = 7;
   localparam int SLOT_W = 6;
   localparam int TAG_W = 64;
   localparam int PAY_W = 32;
   localparam int FUNC_W = 2;

   localparam logic [PTR_W-1:0] NIL = 7'h7F;

   localparam logic [FUNC_W-1:0] FUNC_ENQ = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LIST = 2'd2;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_FULL = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

endpackage

FILE: hdl/lqfl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lqfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/linked_queue_with_free_list.sv
// ----------------------------------------------------------------------------
// Linked queue with free list
// FIFO of customer entries kept as a linked list over a slot memory; free
// slots form a second chain. Operations: enqueue, dequeue, list all.
//
// Request: start with req_func, req_customer_tag, req_payment_cents; a beat
// is taken when start is high and busy is low. Results come one beat per
// cycle on rsp_* marked by rsp_valid; rsp_is_last flags the final beat of
// a request. The receiver cannot stall; every beat is taken as shown.
// Results are registered and show in the cycle after the deciding cycle.
//   full / empty status: answered while idle with busy low, next request the cycle after
//   enqueue: on an empty queue link read, then one link write; else link read,
//   then two link writes through the single write port of the link memory
//   dequeue: link and entry read, then link write
//   list of n entries: one entry per cycle, each next address taken straight
//   from the link memory read data
// Reset: queue empty, all slots free. The link memory is not swept: per-slot
// valid flops cleared by reset make an unwritten link read as its reset
// value, so the block takes requests in the cycle after reset.
// ----------------------------------------------------------------------------
module linked_queue_with_free_list
   import lqfl_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [TAG_W-1:0]  req_customer_tag,
   input  logic [PAY_W-1:0]  req_payment_cents,
   output logic              busy,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [TAG_W-1:0]  rsp_entry_tag,
   output logic [PAY_W-1:0]  rsp_entry_payment,
   output logic              rsp_is_last
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int DATA_W = TAG_W + PAY_W;
   localparam logic [PTR_W-1:0] LIMIT = PTR_W'(SLOTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_WR,
      S_ENQ_LINK,
      S_DEQ_WR,
      S_LST_WALK
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [PTR_W-1:0]  free_head_ff, free_head_in;
   logic [PTR_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [SLOTS-1:0]  lvalid_ff, lvalid_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [PAY_W-1:0]  rsp_pay_ff, rsp_pay_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              link_we;
   logic [IDX_W-1:0]  link_wa;
   logic [PTR_W-1:0]  link_wd;
   logic [PTR_W-1:0]  link_q;
   logic [PTR_W-1:0]  link_rd;
   logic              data_we;
   logic [DATA_W-1:0] data_q;
   logic [IDX_W-1:0]  rd_addr;

   logic              head_ok, tail_ok, free_ok, next_ok, more;

   lqfl_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (rd_addr),
      .rd_data (link_q)
   );

   lqfl_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (cur_ff[IDX_W-1:0]),
      .wr_data ({tag_ff, pay_ff}),
      .rd_addr (rd_addr),
      .rd_data (data_q)
   );

   // unwritten link reads as its reset value: i-1, slot 0 ends the chain
   always_comb begin
      if (lvalid_ff[rd_idx_ff]) begin
         link_rd = link_q;
      end else if (rd_idx_ff == '0) begin
         link_rd = NIL;
      end else begin
         link_rd = PTR_W'(rd_idx_ff) - PTR_W'(1);
      end
   end

   assign head_ok = head_ff < LIMIT;
   assign tail_ok = tail_ff < LIMIT;
   assign free_ok = free_head_ff < LIMIT;
   assign next_ok = link_rd < LIMIT;
   assign more = next_ok && (cnt_ff < CNT_W'(SLOTS));

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      free_head_in = free_head_ff;
      cur_in = cur_ff;
      cnt_in = cnt_ff;
      tag_in = tag_ff;
      pay_in = pay_ff;
      lvalid_in = lvalid_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_tag_in = rsp_tag_ff;
      rsp_pay_in = rsp_pay_ff;
      rsp_last_in = rsp_last_ff;
      link_we = 1'b0;
      link_wa = cur_ff[IDX_W-1:0];
      link_wd = NIL;
      data_we = 1'b0;
      rd_addr = cur_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               tag_in = req_customer_tag;
               pay_in = req_payment_cents;
               unique case (req_func)
                  FUNC_ENQ: begin
                     if (!free_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STAT_FULL;
                        rsp_slot_in = '0;
                        rsp_tag_in = '0;
                        rsp_pay_in = '0;
                        rsp_last_in = 1'b1;
                     end else begin
                        cur_in = free_head_ff;
                        rd_addr = free_head_ff[IDX_W-1:0];
                        state_in = S_ENQ_WR;
                     end
                  end
                  FUNC_DEQ, FUNC_LIST: begin
                     if (!head_ok || !tail_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_slot_in = '0;
                        rsp_tag_in = '0;
                        rsp_pay_in = '0;
                        rsp_last_in = 1'b1;
                     end else begin
                        cur_in = head_ff;
                        cnt_in = CNT_W'(1);
                        rd_addr = head_ff[IDX_W-1:0];
                        state_in = (req_func == FUNC_DEQ) ? S_DEQ_WR : S_LST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ENQ_WR: begin
            free_head_in = link_rd;
            link_we = 1'b1;
            link_wd = NIL;
            data_we = 1'b1;
            if (!head_ok || !tail_ok) begin
               head_in = cur_ff;
               tail_in = cur_ff;
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_slot_in = cur_ff[SLOT_W-1:0];
               rsp_tag_in = '0;
               rsp_pay_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_ENQ_LINK;
            end
         end
         S_ENQ_LINK: begin
            link_we = 1'b1;
            link_wa = tail_ff[IDX_W-1:0];
            link_wd = cur_ff;
            tail_in = cur_ff;
            rsp_valid_in = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_slot_in = cur_ff[SLOT_W-1:0];
            rsp_tag_in = '0;
            rsp_pay_in = '0;
            rsp_last_in = 1'b1;
            state_in = S_IDLE;
         end
         S_DEQ_WR: begin
            if (cur_ff == tail_ff) begin
               head_in = NIL;
               tail_in = NIL;
            end else begin
               head_in = link_rd;
            end
            link_we = 1'b1;
            link_wd = free_head_ff;
            free_head_in = cur_ff;
            rsp_valid_in = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_slot_in = cur_ff[SLOT_W-1:0];
            rsp_tag_in = data_q[DATA_W-1:PAY_W];
            rsp_pay_in = data_q[PAY_W-1:0];
            rsp_last_in = 1'b1;
            state_in = S_IDLE;
         end
         S_LST_WALK: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_slot_in = cur_ff[SLOT_W-1:0];
            rsp_tag_in = data_q[DATA_W-1:PAY_W];
            rsp_pay_in = data_q[PAY_W-1:0];
            rsp_last_in = !more;
            if (more) begin
               cur_in = link_rd;
               rd_addr = link_rd[IDX_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (link_we) begin
         lvalid_in[link_wa] = 1'b1;
      end
      rd_idx_in = rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= NIL;
         tail_ff <= NIL;
         free_head_ff <= PTR_W'(SLOTS - 1);
         lvalid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         free_head_ff <= free_head_in;
         lvalid_ff <= lvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      tag_ff <= tag_in;
      pay_ff <= pay_in;
      rd_idx_ff <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_tag_ff <= rsp_tag_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_entry_tag = rsp_tag_ff;
   assign rsp_entry_payment = rsp_pay_ff;
   assign rsp_is_last = rsp_last_ff;

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_is_last)
      else $error("error status beat not marked last");

   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      (head_ff < LIMIT) == (tail_ff < LIMIT))
      else $error("queue head and tail disagree on emptiness");

   a_deq_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEQ_WR |=> rsp_valid && rsp_is_last)
      else $error("dequeue did not give its single beat");

   a_free_ptr: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff < LIMIT) || (free_head_ff == NIL))
      else $error("free head out of range");

endmodule
